// File: design/svf_lowpass_filter_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef SVF_LOWPASS_FILTER_UNIT_ASSERT_SVH
`define SVF_LOWPASS_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define SVF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define SVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/svf_lpf_pkg.sv
package svf_lpf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STATE_BITS  = 32;
  localparam int COEF_BITS   = 24;
  localparam int G_FRAC      = 20;
  localparam int A_FRAC      = 23;

  // Multiplier operand is a state or a sample-minus-state difference.
  localparam int OPA_BITS   = STATE_BITS + 1;
  localparam int PROD_BITS  = OPA_BITS + COEF_BITS + 1;
  // The smaller fraction count leaves the widest rounded product.
  localparam int RND_BITS   = PROD_BITS - G_FRAC;
  localparam int ACC_BITS   = RND_BITS + 2;
  localparam int TWICE_BITS = STATE_BITS + 2;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [COEF_BITS-1:0] A1_RESET = COEF_BITS'(1 << A_FRAC);
  localparam logic [PROD_BITS-1:0] HALF_G   = PROD_BITS'(1 << (G_FRAC - 1));
  localparam logic [PROD_BITS-1:0] HALF_A   = PROD_BITS'(1 << (A_FRAC - 1));

  typedef enum logic [1:0] {
    REG_GAIN_G,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_COEF_A3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MA_IC1,
    MA_D2,
    MA_D3,
    MA_V
  } mul_a_e;

  typedef enum logic [1:0] {
    CF_G,
    CF_A1,
    CF_A2,
    CF_A3
  } coef_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_LOAD_IC2
  } acc_op_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_WAIT_IN,
    JC_WAIT_OUT
  } jump_e;

  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE = step_t'(0);
  localparam step_t STEP_LAST = step_t'(10);

  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    mul_a_e  mul_a;
    coef_e   coef;
    logic    rnd_en;
    logic    rnd_g;
    acc_op_e acc_op;
    logic    v_wr;
    logic    ic1_wr;
    logic    out_wr;
    jump_e   jc;
    step_t   target;
    logic    done;
  } ucode_t;

  typedef struct packed {
    logic                          clip;
    logic signed [STATE_BITS-1:0]  val;
  } sat_state_t;

  typedef struct packed {
    logic                          clip;
    logic signed [SAMPLE_BITS-1:0] val;
  } sat_sample_t;

  // Microprogram. Each product passes through the product register and the
  // rounding register before it is accumulated.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t u;
    u = '0;
    case (s)
      4'd0: begin
        u.load_in = 1'b1;
        u.jc      = JC_WAIT_IN;
        u.target  = STEP_IDLE;
      end
      4'd1: begin
        u.mul_en = 1'b1;
        u.mul_a  = MA_IC1;
        u.coef   = CF_A1;
      end
      4'd2: begin
        u.mul_en = 1'b1;
        u.mul_a  = MA_D2;
        u.coef   = CF_A2;
        u.rnd_en = 1'b1;
      end
      4'd3: begin
        u.mul_en = 1'b1;
        u.mul_a  = MA_D3;
        u.coef   = CF_A3;
        u.rnd_en = 1'b1;
        u.acc_op = ACC_LOAD;
      end
      4'd4: begin
        u.rnd_en = 1'b1;
        u.acc_op = ACC_ADD;
      end
      4'd5: begin
        u.v_wr   = 1'b1;
        u.acc_op = ACC_LOAD_IC2;
      end
      4'd6: begin
        u.mul_en = 1'b1;
        u.mul_a  = MA_V;
        u.coef   = CF_G;
      end
      4'd7: begin
        u.rnd_en = 1'b1;
        u.rnd_g  = 1'b1;
      end
      4'd8: begin
        u.acc_op = ACC_ADD;
      end
      4'd9: begin
        u.v_wr   = 1'b1;
        u.ic1_wr = 1'b1;
      end
      4'd10: begin
        u.out_wr = 1'b1;
        u.jc     = JC_WAIT_OUT;
        u.target = STEP_LAST;
        u.done   = 1'b1;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

  function automatic sat_state_t sat_state(logic signed [ACC_BITS-1:0] x);
    logic signed [ACC_BITS-1:0] mx;
    logic signed [ACC_BITS-1:0] mn;
    sat_state_t r;
    mx = {{(ACC_BITS - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    mn = ~mx;
    if (x > mx) begin
      r.clip = 1'b1;
      r.val  = mx[STATE_BITS-1:0];
    end else if (x < mn) begin
      r.clip = 1'b1;
      r.val  = mn[STATE_BITS-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = x[STATE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic sat_sample_t sat_sample(logic signed [STATE_BITS-1:0] x);
    logic signed [STATE_BITS-1:0] mx;
    logic signed [STATE_BITS-1:0] mn;
    sat_sample_t r;
    mx = {{(STATE_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    mn = ~mx;
    if (x > mx) begin
      r.clip = 1'b1;
      r.val  = mx[SAMPLE_BITS-1:0];
    end else if (x < mn) begin
      r.clip = 1'b1;
      r.val  = mn[SAMPLE_BITS-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = x[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/svf_lpf_dp.sv
module svf_lpf_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  svf_lpf_pkg::ucode_t                     ctrl_i,
  input  logic signed [svf_lpf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                    frame_end_in_i,
  input  logic [svf_lpf_pkg::COEF_BITS-1:0]       gain_g_i,
  input  logic [svf_lpf_pkg::COEF_BITS-1:0]       coef_a1_i,
  input  logic [svf_lpf_pkg::COEF_BITS-1:0]       coef_a2_i,
  input  logic [svf_lpf_pkg::COEF_BITS-1:0]       coef_a3_i,
  output logic signed [svf_lpf_pkg::SAMPLE_BITS-1:0] lowpass_o,
  output logic                                    frame_end_o,
  output logic                                    clipped_o
);
  import svf_lpf_pkg::*;

  logic signed [OPA_BITS-1:0]    d2_q, d2_d, d3_q, d3_d;
  logic signed [OPA_BITS-1:0]    v0_ext;
  logic signed [STATE_BITS-1:0]  ic1_q, ic1_d, ic2_q, ic2_d;
  logic signed [STATE_BITS-1:0]  v_q, v_d;
  logic signed [PROD_BITS-1:0]   prod_q, prod_d;
  logic signed [PROD_BITS-1:0]   prod_half, rnd_full;
  logic signed [RND_BITS-1:0]    rnd_q, rnd_d;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d;
  logic signed [OPA_BITS-1:0]    opa;
  logic signed [COEF_BITS:0]     opc;
  logic [COEF_BITS-1:0]          coef;
  logic signed [TWICE_BITS-1:0]  ic1_new, ic2_new;
  sat_state_t                    v_sat, ic1_sat, ic2_sat;
  sat_sample_t                   y_sat;
  logic                          clip_q, clip_d;
  logic                          frame_q, frame_d;
  logic signed [SAMPLE_BITS-1:0] lp_q, lp_d;
  logic                          oframe_q, oframe_d;
  logic                          oclip_q, oclip_d;

  assign v0_ext = OPA_BITS'(sample_in_i);

  always_comb begin
    case (ctrl_i.mul_a)
      MA_IC1:  opa = OPA_BITS'(ic1_q);
      MA_D2:   opa = d2_q;
      MA_D3:   opa = d3_q;
      MA_V:    opa = OPA_BITS'(v_q);
      default: opa = '0;
    endcase
    case (ctrl_i.coef)
      CF_G:    coef = gain_g_i;
      CF_A1:   coef = coef_a1_i;
      CF_A2:   coef = coef_a2_i;
      CF_A3:   coef = coef_a3_i;
      default: coef = '0;
    endcase
  end

  assign opc    = {1'b0, coef};
  assign prod_d = ctrl_i.mul_en ? opa * opc : prod_q;

  // Round half up: add half an output LSB, then floor by arithmetic shift.
  assign prod_half = prod_q + (ctrl_i.rnd_g ? HALF_G : HALF_A);
  assign rnd_full  = ctrl_i.rnd_g ? (prod_half >>> G_FRAC) : (prod_half >>> A_FRAC);
  assign rnd_d     = ctrl_i.rnd_en ? RND_BITS'(rnd_full) : rnd_q;

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:     acc_d = ACC_BITS'(rnd_q);
      ACC_ADD:      acc_d = acc_q + ACC_BITS'(rnd_q);
      ACC_LOAD_IC2: acc_d = ACC_BITS'(ic2_q) + ACC_BITS'(rnd_q);
      default:      acc_d = acc_q;
    endcase
  end

  assign ic1_new = (TWICE_BITS'(v_q) <<< 1) - TWICE_BITS'(ic1_q);
  assign ic2_new = (TWICE_BITS'(v_q) <<< 1) - TWICE_BITS'(ic2_q);
  assign v_sat   = sat_state(acc_q);
  assign ic1_sat = sat_state(ACC_BITS'(ic1_new));
  assign ic2_sat = sat_state(ACC_BITS'(ic2_new));
  assign y_sat   = sat_sample(v_q);

  always_comb begin
    d2_d     = d2_q;
    d3_d     = d3_q;
    frame_d  = frame_q;
    clip_d   = clip_q;
    v_d      = v_q;
    ic1_d    = ic1_q;
    ic2_d    = ic2_q;
    lp_d     = lp_q;
    oframe_d = oframe_q;
    oclip_d  = oclip_q;
    if (ctrl_i.load_in) begin
      d2_d    = v0_ext - OPA_BITS'(ic2_q);
      d3_d    = v0_ext - OPA_BITS'(ic1_q);
      frame_d = frame_end_in_i;
      clip_d  = 1'b0;
    end
    if (ctrl_i.v_wr) begin
      v_d    = v_sat.val;
      clip_d = clip_d | v_sat.clip;
    end
    if (ctrl_i.ic1_wr) begin
      ic1_d  = ic1_sat.val;
      clip_d = clip_d | ic1_sat.clip;
    end
    if (ctrl_i.out_wr) begin
      ic2_d    = ic2_sat.val;
      lp_d     = y_sat.val;
      oframe_d = frame_q;
      oclip_d  = clip_q | ic2_sat.clip | y_sat.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic1_q <= '0;
      ic2_q <= '0;
    end else begin
      ic1_q <= ic1_d;
      ic2_q <= ic2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q     <= d2_d;
    d3_q     <= d3_d;
    frame_q  <= frame_d;
    clip_q   <= clip_d;
    v_q      <= v_d;
    prod_q   <= prod_d;
    rnd_q    <= rnd_d;
    acc_q    <= acc_d;
    lp_q     <= lp_d;
    oframe_q <= oframe_d;
    oclip_q  <= oclip_d;
  end

  assign lowpass_o   = lp_q;
  assign frame_end_o = oframe_q;
  assign clipped_o   = oclip_q;

endmodule

// File: design/svf_lowpass_filter_unit.sv
// Channel | Handshake                   | Payload
// --------+-----------------------------+--------------------------------------
// input   | in_valid_i / in_ready_o     | sample_in_i, frame_end_in_i
// output  | out_valid_o / out_ready_i   | lowpass_out_o, frame_end_out_o, clipped_o
// config  | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// The microprogram runs all four coefficient products through a single
// shared multiplier.
// A new sample is taken once the program is back at its first step, while the
// previous result may still wait in the output register.
// The last step waits while a result is held unread in the output register.
// Reset clears both integrator states and loads the default coefficients.
module svf_lowpass_filter_unit (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [svf_lpf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                       frame_end_in_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [svf_lpf_pkg::SAMPLE_BITS-1:0] lowpass_out_o,
  output logic                                       frame_end_out_o,
  output logic                                       clipped_o,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [svf_lpf_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [svf_lpf_pkg::DATA_BITS-1:0]          pwdata,
  output logic [svf_lpf_pkg::DATA_BITS-1:0]          prdata,
  output logic                                       pready
);
  import svf_lpf_pkg::*;

  step_t                step_q, step_d;
  ucode_t               uc, ctrl;
  logic                 cond_hit;
  logic                 out_valid_q, out_valid_d;
  logic [COEF_BITS-1:0] gain_g_q, gain_g_d;
  logic [COEF_BITS-1:0] coef_a1_q, coef_a1_d;
  logic [COEF_BITS-1:0] coef_a2_q, coef_a2_d;
  logic [COEF_BITS-1:0] coef_a3_q, coef_a3_d;
  logic                 cfg_wr;
  reg_idx_e             reg_idx;

  assign uc = ucode_rom(step_q);

  always_comb begin
    case (uc.jc)
      JC_WAIT_IN:  cond_hit = !in_valid_i;
      JC_WAIT_OUT: cond_hit = out_valid_q && !out_ready_i;
      default:     cond_hit = 1'b0;
    endcase
  end

  // A step that waits on a condition performs none of its writes.
  always_comb begin
    ctrl = uc;
    if (cond_hit) begin
      ctrl.load_in = 1'b0;
      ctrl.mul_en  = 1'b0;
      ctrl.rnd_en  = 1'b0;
      ctrl.acc_op  = ACC_HOLD;
      ctrl.v_wr    = 1'b0;
      ctrl.ic1_wr  = 1'b0;
      ctrl.out_wr  = 1'b0;
    end
  end

  always_comb begin
    if (cond_hit) begin
      step_d = uc.target;
    end else if (uc.done) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_comb begin
    if (ctrl.out_wr) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (step_q == STEP_IDLE);
  assign out_valid_o = out_valid_q;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    gain_g_d  = gain_g_q;
    coef_a1_d = coef_a1_q;
    coef_a2_d = coef_a2_q;
    coef_a3_d = coef_a3_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_G:  gain_g_d  = pwdata[COEF_BITS-1:0];
        REG_COEF_A1: coef_a1_d = pwdata[COEF_BITS-1:0];
        REG_COEF_A2: coef_a2_d = pwdata[COEF_BITS-1:0];
        REG_COEF_A3: coef_a3_d = pwdata[COEF_BITS-1:0];
        default:     gain_g_d  = gain_g_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_G:  prdata = DATA_BITS'(gain_g_q);
      REG_COEF_A1: prdata = DATA_BITS'(coef_a1_q);
      REG_COEF_A2: prdata = DATA_BITS'(coef_a2_q);
      REG_COEF_A3: prdata = DATA_BITS'(coef_a3_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
      gain_g_q    <= '0;
      coef_a1_q   <= A1_RESET;
      coef_a2_q   <= '0;
      coef_a3_q   <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      gain_g_q    <= gain_g_d;
      coef_a1_q   <= coef_a1_d;
      coef_a2_q   <= coef_a2_d;
      coef_a3_q   <= coef_a3_d;
    end
  end

  svf_lpf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sample_in_i    (sample_in_i),
    .frame_end_in_i (frame_end_in_i),
    .gain_g_i       (gain_g_q),
    .coef_a1_i      (coef_a1_q),
    .coef_a2_i      (coef_a2_q),
    .coef_a3_i      (coef_a3_q),
    .lowpass_o      (lowpass_out_o),
    .frame_end_o    (frame_end_out_o),
    .clipped_o      (clipped_o)
  );

endmodule

// File: design/svf_lpf_checker.sv
`include "svf_lowpass_filter_unit_assert.svh"

module svf_lpf_checker (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       in_valid_i,
  input logic                                       in_ready_o,
  input logic                                       out_valid_o,
  input logic                                       out_ready_i,
  input logic signed [svf_lpf_pkg::SAMPLE_BITS-1:0] lowpass_out_o,
  input logic                                       frame_end_out_o,
  input logic                                       clipped_o
);

  // A held result keeps its sample and flags until it is taken.
  `SVF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(lowpass_out_o) && $stable(frame_end_out_o) && $stable(clipped_o), "output changed while stalled")

  // The filter works on one sample at a time.
  `SVF_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // A new result appears only as the sequencer finishes a sample.
  `SVF_ASSERT_NOW(a_result_at_end, $rose(out_valid_o), in_ready_o && !$past(in_ready_o), "result out of sequence")

endmodule

bind svf_lowpass_filter_unit svf_lpf_checker u_svf_lpf_checker (.*);
